[sv/assert_macros.svh]
// Assertion macros shared by the list unit RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ILST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ilst: assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define ILST_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ilst: forbidden condition seen");
`else
`define ILST_ASSERT(lbl, clk, rst, prop)
`define ILST_NEVER(lbl, clk, rst, expr)
`endif
`endif

[sv/ilst_pkg.sv]
// Package for the indexed insert/remove list unit: sizes, codes and types.
// No dependencies; used by every other RTL file but ilst_ram.
`timescale 1ns / 1ps

package ilst_pkg;

   // List storage
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // Field widths
   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CMP_W    = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Command selector codes
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      OP_READ,
      OP_WRITE,
      OP_INSERT,
      OP_REMOVE,
      OP_DUMP
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  value;
   } cmd_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_EMIT,
      ST_SH_RD,
      ST_SH_WR,
      ST_FIN,
      ST_DMP_EMIT
   } state_type;

endpackage

[sv/ilst_if.sv]
// Valid/ready channel interfaces for commands and results of the list unit.
// Depends on ilst_pkg for field widths.
`timescale 1ns / 1ps

interface ilst_req_if;
   logic                                valid;
   logic                                ready;
   logic [ilst_pkg::CMD_W-1:0]          cmd;
   logic [ilst_pkg::INDEX_W-1:0]        index;
   logic signed [ilst_pkg::DATA_W-1:0]  value;

   modport source (output valid, output cmd, output index, output value, input ready);
   modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface ilst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ilst_pkg::DATA_W-1:0]  data;
   logic [ilst_pkg::STATUS_W-1:0]       status;
   logic                                last;

   modport source (output valid, output data, output status, output last, input ready);
   modport sink   (input valid, input data, input status, input last, output ready);
endinterface

[sv/indexed_insert_remove_list_unit.sv]
// Channel   | Dir | Handshake   | Payload
// req_chan  | in  | valid/ready | cmd[2:0], index[5:0], value[31:0] signed
// rsp_chan  | out | valid/ready | data[31:0] signed, status[1:0], last
//
// One command runs at a time in the engine; a two-entry queue lets the
// front keep taking transfers meanwhile. Insert at an occupied index and
// remove shift the entries above the index one step at a time, a read then
// a write, as set by the one read and one write port of the entry RAM.
// Reset clears the count, the queue and the engine; no RAM clearing pass.
// A stalled result holds the engine only when it has a result to load.
// Top level of the list unit; depends on ilst_pkg, ilst_if and submodules.
`timescale 1ns / 1ps

module indexed_insert_remove_list_unit (
   input  logic         clock,
   input  logic         reset,
   ilst_req_if.sink     req_chan,
   ilst_rsp_if.source   rsp_chan
);

   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_valid;
   ilst_pkg::cmd_entry_type  q_entry;
   ilst_pkg::cmd_entry_type  q_head;

   ilst_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   ilst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   ilst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[sv/ilst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ilst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ilst_front.sv]
// Front end: takes command transfers, decodes the selector and forwards
// valid commands to the queue. Depends on ilst_pkg and ilst_if.
`timescale 1ns / 1ps

module ilst_front (
   ilst_req_if.sink                 req_chan,
   input  logic                     q_full,
   output logic                     q_push,
   output ilst_pkg::cmd_entry_type  q_entry
);

   logic             known;
   ilst_pkg::op_type op;

   // Selector decode; undefined codes are taken and dropped
   always_comb begin
      known = 1'b1;
      op    = ilst_pkg::OP_READ;
      unique case (req_chan.cmd)
         ilst_pkg::CMD_READ:   op = ilst_pkg::OP_READ;
         ilst_pkg::CMD_WRITE:  op = ilst_pkg::OP_WRITE;
         ilst_pkg::CMD_INSERT: op = ilst_pkg::OP_INSERT;
         ilst_pkg::CMD_REMOVE: op = ilst_pkg::OP_REMOVE;
         ilst_pkg::CMD_DUMP:   op = ilst_pkg::OP_DUMP;
         default:              known = 1'b0;
      endcase
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full && known;
   assign q_entry.op     = op;
   assign q_entry.index  = req_chan.index;
   assign q_entry.value  = req_chan.value;

endmodule

[sv/ilst_queue.sv]
// Small command FIFO between the front end and the list engine.
// Depends on ilst_pkg.
`timescale 1ns / 1ps

module ilst_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ilst_pkg::cmd_entry_type  push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output ilst_pkg::cmd_entry_type  head
);

   ilst_pkg::cmd_entry_type             slot_ff [ilst_pkg::QUEUE_DEPTH];
   logic [ilst_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [ilst_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [ilst_pkg::QFILL_W-1:0]        fill_ff, fill_in;

   function automatic logic [ilst_pkg::QPTR_W-1:0] bump(input logic [ilst_pkg::QPTR_W-1:0] p);
      if (p == ilst_pkg::QPTR_W'(ilst_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + ilst_pkg::QPTR_W'(1);
   endfunction

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + ilst_pkg::QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - ilst_pkg::QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (fill_ff == ilst_pkg::QFILL_W'(ilst_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

endmodule

[sv/ilst_back.sv]
// List engine: executes queued commands against the entry RAM, shifts
// entries for insert/remove and drives the result output register.
// Depends on ilst_pkg, ilst_if, ilst_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilst_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  ilst_pkg::cmd_entry_type  q_head,
   output logic                     q_pop,
   ilst_rsp_if.source               rsp_chan
);

   localparam int AW = ilst_pkg::ADDR_W;
   localparam int CW = ilst_pkg::CNT_W;
   localparam int DW = ilst_pkg::DATA_W;
   localparam int SW = ilst_pkg::STATUS_W;

   ilst_pkg::state_type   state_ff, state_in;
   ilst_pkg::op_type      cur_op_ff, cur_op_in;
   logic [AW-1:0]         cur_idx_ff, cur_idx_in;
   logic [DW-1:0]         cur_val_ff, cur_val_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   logic                  rsp_valid_ff;
   logic [DW-1:0]         rsp_data_ff;
   logic [SW-1:0]         rsp_status_ff;
   logic                  rsp_last_ff;

   logic                  rsp_load;
   logic [DW-1:0]         ld_data;
   logic [SW-1:0]         ld_status;
   logic                  ld_last;
   logic                  out_free;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DW-1:0]         rd_data;

   logic                  head_occ;
   logic                  list_full;
   logic                  list_empty;
   logic [CW-1:0]         src;
   logic [CW-1:0]         cur_idx_ext;
   logic                  dump_last;
   logic                  ins_shift_rd;
   logic                  count_hold;

   ilst_ram #(
      .WIDTH (DW),
      .DEPTH (ilst_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Classification helpers
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign head_occ    = ilst_pkg::CMP_W'(q_head.index) < ilst_pkg::CMP_W'(count_ff);
   assign list_full   = (count_ff == CW'(ilst_pkg::DEPTH));
   assign list_empty  = (count_ff == '0);
   assign cur_idx_ext = CW'(cur_idx_ff);
   assign src         = (cur_op_ff == ilst_pkg::OP_INSERT) ? (ptr_ff - CW'(1))
                                                          : (ptr_ff + CW'(1));
   assign dump_last   = ((ptr_ff + CW'(1)) == count_ff);

   // Next state and datapath control
   always_comb begin
      state_in   = state_ff;
      cur_op_in  = cur_op_ff;
      cur_idx_in = cur_idx_ff;
      cur_val_in = cur_val_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      q_pop      = 1'b0;
      rsp_load   = 1'b0;
      ld_data    = '0;
      ld_status  = ilst_pkg::STATUS_EMPTY;
      ld_last    = 1'b1;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;

      unique case (state_ff)
         ilst_pkg::ST_IDLE: begin
            if (q_valid) begin
               cur_op_in  = q_head.op;
               cur_idx_in = q_head.index[AW-1:0];
               cur_val_in = q_head.value;
               unique case (q_head.op)
                  ilst_pkg::OP_READ: begin
                     if (head_occ) begin
                        q_pop    = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = q_head.index[AW-1:0];
                        state_in = ilst_pkg::ST_RD_EMIT;
                     end else if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  ilst_pkg::OP_WRITE: begin
                     if (head_occ) begin
                        q_pop   = 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = q_head.index[AW-1:0];
                        wr_data = q_head.value;
                     end else if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  ilst_pkg::OP_INSERT: begin
                     if (list_full) begin
                        if (out_free) begin
                           q_pop     = 1'b1;
                           rsp_load  = 1'b1;
                           ld_status = ilst_pkg::STATUS_FULL;
                        end
                     end else if (head_occ) begin
                        // Open a gap: shift entries up from the top
                        q_pop    = 1'b1;
                        ptr_in   = count_ff;
                        state_in = ilst_pkg::ST_SH_RD;
                     end else begin
                        // Append at the end of the list
                        q_pop    = 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = q_head.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ilst_pkg::OP_REMOVE: begin
                     if (head_occ) begin
                        q_pop    = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = q_head.index[AW-1:0];
                        ptr_in   = CW'(q_head.index[AW-1:0]);
                        state_in = ilst_pkg::ST_RD_EMIT;
                     end else if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  ilst_pkg::OP_DUMP: begin
                     if (!list_empty) begin
                        q_pop    = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        ptr_in   = '0;
                        state_in = ilst_pkg::ST_DMP_EMIT;
                     end else if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Word read for read or remove is in rd_data
         ilst_pkg::ST_RD_EMIT: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               ld_data   = rd_data;
               ld_status = ilst_pkg::STATUS_OK;
               if (cur_op_ff == ilst_pkg::OP_REMOVE) begin
                  if ((ptr_ff + CW'(1)) < count_ff) begin
                     state_in = ilst_pkg::ST_SH_RD;
                  end else begin
                     state_in = ilst_pkg::ST_FIN;
                  end
               end else begin
                  state_in = ilst_pkg::ST_IDLE;
               end
            end
         end

         // One shift step: read the neighbor, then write it into ptr
         ilst_pkg::ST_SH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = src[AW-1:0];
            state_in = ilst_pkg::ST_SH_WR;
         end

         ilst_pkg::ST_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data;
            ptr_in  = src;
            if (cur_op_ff == ilst_pkg::OP_INSERT) begin
               state_in = (src == cur_idx_ext) ? ilst_pkg::ST_FIN : ilst_pkg::ST_SH_RD;
            end else begin
               state_in = ((src + CW'(1)) == count_ff) ? ilst_pkg::ST_FIN
                                                       : ilst_pkg::ST_SH_RD;
            end
         end

         // Finish insert/remove; the freed top slot on remove is never read
         // before it is written again, so it is left as is
         ilst_pkg::ST_FIN: begin
            if (cur_op_ff == ilst_pkg::OP_INSERT) begin
               wr_en    = 1'b1;
               wr_addr  = cur_idx_ff;
               wr_data  = cur_val_ff;
               count_in = count_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
            state_in = ilst_pkg::ST_IDLE;
         end

         // Dump: emit the word in rd_data and fetch the next one
         ilst_pkg::ST_DMP_EMIT: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               ld_data   = rd_data;
               ld_status = ilst_pkg::STATUS_OK;
               ld_last   = dump_last;
               if (dump_last) begin
                  state_in = ilst_pkg::ST_IDLE;
               end else begin
                  ptr_in  = ptr_ff + CW'(1);
                  rd_en   = 1'b1;
                  rd_addr = ptr_in[AW-1:0];
               end
            end
         end

         default: state_in = ilst_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      cur_op_ff  <= cur_op_in;
      cur_idx_ff <= cur_idx_in;
      cur_val_ff <= cur_val_in;
      ptr_ff     <= ptr_in;
      if (rsp_load) begin
         rsp_data_ff   <= ld_data;
         rsp_status_ff <= ld_status;
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // Check terms
   assign ins_shift_rd = (state_ff == ilst_pkg::ST_SH_RD) && (cur_op_ff == ilst_pkg::OP_INSERT);
   assign count_hold   = (state_ff != ilst_pkg::ST_IDLE) && (state_ff != ilst_pkg::ST_FIN);

   // Checks
   `ILST_NEVER(a_count_bound, clock, reset, count_ff > CW'(ilst_pkg::DEPTH))
   `ILST_ASSERT(a_pop_idle, clock, reset, q_pop |-> (state_ff == ilst_pkg::ST_IDLE))
   `ILST_ASSERT(a_load_free, clock, reset, rsp_load |-> out_free)
   `ILST_ASSERT(a_ins_ptr, clock, reset, ins_shift_rd |-> (ptr_ff > cur_idx_ext))
   `ILST_ASSERT(a_count_steady, clock, reset, count_hold |=> $stable(count_ff))

endmodule

[test/ilst_checker.sv]
// Checker for the indexed insert/remove list unit: tracks the list contents
// from command transfers and compares every result transfer against them.
// Depends on ilst_pkg and the channel interfaces in ilst_if.
`timescale 1ns / 1ps

module ilst_checker (
   input  logic   clock,
   input  logic   reset,
   ilst_req_if    req_mon,
   ilst_rsp_if    rsp_mon,
   output int     mismatch_count,
   output int     rsp_pending,
   output int     rsp_checked
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [ilst_pkg::DATA_W-1:0]  data;
      logic [ilst_pkg::STATUS_W-1:0]       status;
      logic                                last;
   } list_rsp_type;

   // Shadow copy of the list and the results it still owes
   logic signed [ilst_pkg::DATA_W-1:0]  list_words [ilst_pkg::DEPTH];
   int                                  word_count = 0;
   list_rsp_type                        list_rsp_q [$];

   int errors  = 0;
   int checked = 0;
   int pending = 0;

   assign mismatch_count = errors;
   assign rsp_pending    = pending;
   assign rsp_checked    = checked;

   function automatic void owe_rsp(input logic signed [ilst_pkg::DATA_W-1:0] data,
                                   input logic [ilst_pkg::STATUS_W-1:0] status,
                                   input logic last);
      list_rsp_type r;
      r.data   = data;
      r.status = status;
      r.last   = last;
      list_rsp_q.push_back(r);
   endfunction

   // Apply one command to the shadow list and queue the results it causes
   function automatic void update_list(input logic [ilst_pkg::CMD_W-1:0] code,
                                       input logic [ilst_pkg::INDEX_W-1:0] idx,
                                       input logic signed [ilst_pkg::DATA_W-1:0] word);
      int  i;
      int  pos;
      bit  held;
      held = int'(idx) < word_count;
      case (code)
         ilst_pkg::CMD_READ: begin
            if (held) owe_rsp(list_words[idx], ilst_pkg::STATUS_OK, 1'b1);
            else      owe_rsp('0, ilst_pkg::STATUS_EMPTY, 1'b1);
         end
         ilst_pkg::CMD_WRITE: begin
            if (held) list_words[idx] = word;
            else      owe_rsp('0, ilst_pkg::STATUS_EMPTY, 1'b1);
         end
         ilst_pkg::CMD_INSERT: begin
            if (word_count >= ilst_pkg::DEPTH) begin
               owe_rsp('0, ilst_pkg::STATUS_FULL, 1'b1);
            end else begin
               // occupied index shifts the tail up, otherwise append
               pos = held ? int'(idx) : word_count;
               for (i = word_count; i > pos; i--)
                  list_words[i] = list_words[i-1];
               list_words[pos] = word;
               word_count++;
            end
         end
         ilst_pkg::CMD_REMOVE: begin
            if (held) begin
               owe_rsp(list_words[idx], ilst_pkg::STATUS_OK, 1'b1);
               for (i = int'(idx); i + 1 < word_count; i++)
                  list_words[i] = list_words[i+1];
               list_words[word_count-1] = '0;
               word_count--;
            end else begin
               owe_rsp('0, ilst_pkg::STATUS_EMPTY, 1'b1);
            end
         end
         ilst_pkg::CMD_DUMP: begin
            if (word_count == 0) begin
               owe_rsp('0, ilst_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               for (i = 0; i < word_count; i++)
                  owe_rsp(list_words[i], ilst_pkg::STATUS_OK, i + 1 == word_count);
            end
         end
         default: ;  // spare selectors are ignored
      endcase
   endfunction

   // Commands are applied before results are checked in the same cycle
   always @(posedge clock) begin : watch
      list_rsp_type want;
      if (reset) begin
         foreach (list_words[k]) list_words[k] = '0;
         word_count = 0;
         list_rsp_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            update_list(req_mon.cmd, req_mon.index, req_mon.value);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (list_rsp_q.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("%0t: unexpected result data=%0d status=%0d last=%0d",
                           $time, rsp_mon.data, rsp_mon.status, rsp_mon.last);
               errors++;
            end else begin
               want = list_rsp_q.pop_front();
               if (rsp_mon.data !== want.data || rsp_mon.status !== want.status ||
                   rsp_mon.last !== want.last) begin
                  if (errors < REPORT_LIMIT)
                     $display("%0t: result %0d mismatch: expected data=%0d status=%0d last=%0d,",
                              $time, checked, want.data, want.status, want.last,
                              " got data=%0d status=%0d last=%0d",
                              rsp_mon.data, rsp_mon.status, rsp_mon.last);
                  errors++;
               end
               checked++;
            end
         end
      end
      pending = list_rsp_q.size();
   end

endmodule

[test/testbench.sv]
// Top of the list unit testbench: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on ilst_pkg, ilst_if, ilst_checker
// and the RTL top indexed_insert_remove_list_unit.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 370;
   localparam int QUIET_ITEMS  = 60;
   localparam int TAIL_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 1000000;

   // Selectors with no defined operation
   localparam logic [ilst_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [ilst_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
   localparam logic [ilst_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

   localparam logic signed [ilst_pkg::DATA_W-1:0] WORD_MIN =
      {1'b1, {(ilst_pkg::DATA_W-1){1'b0}}};
   localparam logic signed [ilst_pkg::DATA_W-1:0] WORD_MAX =
      {1'b0, {(ilst_pkg::DATA_W-1){1'b1}}};

   typedef enum {PHASE_GROW, PHASE_MIXED, PHASE_SHRINK} load_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ilst_req_if req_chan ();
   ilst_rsp_if rsp_chan ();

   int mismatch_count;
   int rsp_pending;
   int rsp_checked;

   bit quiet       = 1'b0;
   int list_fill   = 0;
   int peak_fill   = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   int op_tally [5];

   indexed_insert_remove_list_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ilst_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .rsp_pending    (rsp_pending),
      .rsp_checked    (rsp_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL indexed_insert_remove_list_unit");
         $finish;
      end
   end

   // Result back-pressure in random bursts, none in the quiet tail
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(1, 10) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // One command transfer, with an occasional idle burst ahead of it
   task automatic send_cmd(input logic [ilst_pkg::CMD_W-1:0] code,
                           input logic [ilst_pkg::INDEX_W-1:0] idx,
                           input logic signed [ilst_pkg::DATA_W-1:0] word);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= code;
      req_chan.index <= idx;
      req_chan.value <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // fill level kept only to steer the random mix
      if (code <= ilst_pkg::CMD_DUMP) op_tally[code]++;
      if (code == ilst_pkg::CMD_INSERT && list_fill < ilst_pkg::DEPTH) list_fill++;
      if (code == ilst_pkg::CMD_REMOVE && int'(idx) < list_fill) list_fill--;
      if (list_fill > peak_fill) peak_fill = list_fill;
   endtask

   // Hold off until every owed result has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (rsp_pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [ilst_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return '1;
         4:       return ilst_pkg::DATA_W'($urandom_range(1, 15));
         default: return ilst_pkg::DATA_W'($urandom());
      endcase
   endfunction

   // Mostly occupied slots, sometimes the append slot or anywhere
   function automatic logic [ilst_pkg::INDEX_W-1:0] pick_index();
      int roll;
      roll = $urandom_range(0, 9);
      if (list_fill > 0 && roll < 7)
         return ilst_pkg::INDEX_W'($urandom_range(0, list_fill - 1));
      if (roll == 7 && list_fill < ilst_pkg::DEPTH)
         return ilst_pkg::INDEX_W'(list_fill);
      return ilst_pkg::INDEX_W'($urandom_range(0, ilst_pkg::DEPTH - 1));
   endfunction

   function automatic logic [ilst_pkg::CMD_W-1:0] pick_code(input load_phase_type phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW: begin
            if (roll < 80) return ilst_pkg::CMD_INSERT;
            if (roll < 85) return ilst_pkg::CMD_REMOVE;
            if (roll < 92) return ilst_pkg::CMD_READ;
            if (roll < 97) return ilst_pkg::CMD_WRITE;
            if (roll < 98) return ilst_pkg::CMD_DUMP;
         end
         PHASE_SHRINK: begin
            if (roll < 75) return ilst_pkg::CMD_REMOVE;
            if (roll < 85) return ilst_pkg::CMD_READ;
            if (roll < 93) return ilst_pkg::CMD_WRITE;
            if (roll < 97) return ilst_pkg::CMD_INSERT;
            if (roll < 99) return ilst_pkg::CMD_DUMP;
         end
         default: begin
            if (roll < 25) return ilst_pkg::CMD_READ;
            if (roll < 45) return ilst_pkg::CMD_WRITE;
            if (roll < 70) return ilst_pkg::CMD_INSERT;
            if (roll < 92) return ilst_pkg::CMD_REMOVE;
            if (roll < 97) return ilst_pkg::CMD_DUMP;
         end
      endcase
      return ilst_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
   endfunction

   initial begin
      int                          sent;
      logic [ilst_pkg::CMD_W-1:0]  code;
      load_phase_type              phase;

      req_chan.valid = 1'b0;
      req_chan.cmd   = ilst_pkg::CMD_READ;
      req_chan.index = '0;
      req_chan.value = '0;
      foreach (op_tally[k]) op_tally[k] = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, appends and shifts with extreme words, spare codes
      send_cmd(ilst_pkg::CMD_DUMP,   '0, '0);
      send_cmd(ilst_pkg::CMD_READ,   '0, '0);
      send_cmd(ilst_pkg::CMD_WRITE,  '1, WORD_MAX);
      send_cmd(ilst_pkg::CMD_REMOVE, '0, '0);
      send_cmd(ilst_pkg::CMD_INSERT, '1, WORD_MIN);           // append from far past the count
      send_cmd(ilst_pkg::CMD_INSERT, 6'd1, WORD_MAX);         // append exactly at the count
      send_cmd(ilst_pkg::CMD_INSERT, '0, '0);                 // shift at the head, zero word
      send_cmd(ilst_pkg::CMD_INSERT, 6'd1, '1);
      send_cmd(ilst_pkg::CMD_READ,   '0, '0);
      send_cmd(ilst_pkg::CMD_READ,   6'd3, '0);
      send_cmd(ilst_pkg::CMD_READ,   6'd4, '0);
      send_cmd(ilst_pkg::CMD_READ,   '1, '0);
      send_cmd(ilst_pkg::CMD_WRITE,  6'd2, 32'sh5A5A_A5A5);
      send_cmd(ilst_pkg::CMD_WRITE,  6'd4, WORD_MIN);
      send_cmd(CMD_SPARE_LO,  '0, WORD_MAX);
      send_cmd(CMD_SPARE_MID, 6'd1, '1);
      send_cmd(CMD_SPARE_HI,  '1, WORD_MIN);
      send_cmd(ilst_pkg::CMD_DUMP,   '0, '0);
      send_cmd(ilst_pkg::CMD_REMOVE, 6'd1, '0);
      send_cmd(ilst_pkg::CMD_REMOVE, 6'd2, '0);               // remove the last word
      send_cmd(ilst_pkg::CMD_REMOVE, 6'd5, '0);
      send_cmd(ilst_pkg::CMD_INSERT, '0, 32'sd1);
      send_cmd(ilst_pkg::CMD_DUMP,   '1, '1);
      wait_drained();

      // Random: fill to full and past it, mix, drain down, mix again
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < 120)      phase = PHASE_GROW;
         else if (sent < 200) phase = PHASE_MIXED;
         else if (sent < 290) phase = PHASE_SHRINK;
         else                 phase = PHASE_MIXED;
         if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         code = pick_code(phase);
         send_cmd(code, pick_index(), pick_word());
         if (code <= ilst_pkg::CMD_DUMP) begin
            sent++;
            if (sent == 150 || sent == 250) wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d read, %0d write, %0d insert, %0d remove, %0d dump",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3] + op_tally[4],
               op_tally[ilst_pkg::CMD_READ], op_tally[ilst_pkg::CMD_WRITE],
               op_tally[ilst_pkg::CMD_INSERT], op_tally[ilst_pkg::CMD_REMOVE],
               op_tally[ilst_pkg::CMD_DUMP]);
      $display("List reached %0d of %0d words; %0d results checked, %0d mismatches",
               peak_fill, ilst_pkg::DEPTH, rsp_checked, mismatch_count);
      if (mismatch_count == 0 && rsp_pending == 0) begin
         $display("PASS indexed_insert_remove_list_unit");
      end else begin
         $display("FAIL indexed_insert_remove_list_unit");
      end
      $finish;
   end

endmodule
